>>> design/tsfp_pkg.sv
// Shared types and constants for the temperature sensor frame parser.
package tsfp_pkg;

  localparam int unsigned PosW       = 5;
  localparam int unsigned FieldCount = 7;
  localparam logic [7:0]  FuncCode   = 8'h03;
  localparam logic [7:0]  HdrLimit   = 8'd16;
  localparam logic [7:0]  AddrReset  = 8'd164;

  localparam logic [PosW-1:0] PosAddr  = 5'd0;
  localparam logic [PosW-1:0] PosFunc  = 5'd1;
  localparam logic [PosW-1:0] PosStart = 5'd2;
  localparam logic [PosW-1:0] PosLen   = 5'd3;
  localparam logic [PosW-1:0] PosField = 5'd4;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [PosW-1:0] len;
    logic [7:0]      sum;
  } ctl_t;

  typedef logic [FieldCount-1:0][7:0] fields_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [15:0] object_temp;
    logic [15:0] ambient_temp;
    logic [15:0] body_temp;
    logic [7:0]  emissivity;
  } result_t;

endpackage

>>> design/tsfp_core.sv
// Per-byte frame parsing step: next parser state, field capture and result.
module tsfp_core #(
  parameter int unsigned MAX_FRAME_BYTES = 21
) (
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        frame_address_i,
  input  tsfp_pkg::ctl_t    ctl_i,
  input  tsfp_pkg::fields_t fields_i,
  output tsfp_pkg::ctl_t    ctl_o,
  output tsfp_pkg::fields_t fields_o,
  output logic              emit_o,
  output tsfp_pkg::result_t result_o
);
  import tsfp_pkg::*;

  localparam logic [PosW:0] MaxPos = (PosW+1)'(MAX_FRAME_BYTES);

  logic              mismatch;
  logic [PosW:0]     nxt;
  logic [PosW:0]     end_pos;
  logic              at_limit;
  logic              ok;
  fields_t           fb;

  assign mismatch = ((ctl_i.pos == PosAddr)  && (rx_byte_i != frame_address_i)) ||
                    ((ctl_i.pos == PosFunc)  && (rx_byte_i != FuncCode)) ||
                    ((ctl_i.pos == PosStart) && (rx_byte_i > HdrLimit)) ||
                    ((ctl_i.pos == PosLen)   && (rx_byte_i > HdrLimit));

  assign nxt      = {1'b0, ctl_i.pos} + (PosW+1)'(1);
  assign end_pos  = {1'b0, ctl_i.len} + (PosW+1)'(5);
  assign at_limit = (nxt > (PosW+1)'(3)) && (nxt >= MaxPos);
  assign emit_o   = !mismatch && !at_limit && (nxt > (PosW+1)'(3)) && (nxt == end_pos);
  assign ok       = (ctl_i.sum == rx_byte_i);

  always_comb begin
    for (int k = 0; k < FieldCount; k++) begin
      fb[k] = (ctl_i.pos == PosField + PosW'(k)) ? rx_byte_i : fields_i[k];
    end
  end

  always_comb begin
    result_o.checksum_ok  = ok;
    result_o.object_temp  = ok ? {fb[1], fb[2]} : 16'd0;
    result_o.ambient_temp = ok ? {fb[3], fb[4]} : 16'd0;
    result_o.body_temp    = ok ? {fb[5], fb[6]} : 16'd0;
    result_o.emissivity   = ok ? fb[0] : 8'd0;
  end

  always_comb begin
    ctl_o    = ctl_i;
    fields_o = fields_i;
    if (mismatch) begin
      ctl_o.pos = '0;
      ctl_o.sum = '0;
    end else begin
      fields_o = fb;
      if (ctl_i.pos == PosLen) begin
        ctl_o.len = rx_byte_i[PosW-1:0];
      end
      if (at_limit) begin
        ctl_o.pos = '0;
        ctl_o.sum = '0;
      end else if (emit_o) begin
        fields_o  = '0;
        ctl_o.pos = '0;
        ctl_o.sum = '0;
      end else begin
        ctl_o.sum = ctl_i.sum + rx_byte_i;
        ctl_o.pos = nxt[PosW-1:0];
      end
    end
  end

endmodule

>>> design/temp_sensor_frame_parser.sv
// Top level of the temperature sensor frame parser: item registers and parser state.
// Takes one received byte per item and emits one result per frame, on its checksum byte.
// A byte enters an input register, is parsed against the frame state in the next cycle,
// and a result lands in an output register; one item per cycle is sustained while the
// output side does not stall. Only a result held while the output side stalls can hold
// back the input register. frame_address is matched at the start of each frame and
// should be written while no item is in flight.
module temp_sensor_frame_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        checksum_ok_o,
  output logic [15:0] object_temp_o,
  output logic [15:0] ambient_temp_o,
  output logic [15:0] body_temp_o,
  output logic [7:0]  emissivity_o
);
  import tsfp_pkg::*;

  logic [7:0] addr_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  ctl_t       ctl_q, ctl_d;
  fields_t    fields_q, fields_d;
  logic       emit;
  result_t    res_d, res_q;
  logic       out_valid_q;
  logic       out_free;
  logic       advance;

  tsfp_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .rx_byte_i      (in_byte_q),
    .frame_address_i(addr_q),
    .ctl_i          (ctl_q),
    .fields_i       (fields_q),
    .ctl_o          (ctl_d),
    .fields_o       (fields_d),
    .emit_o         (emit),
    .result_o       (res_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= AddrReset;
    end else if (cfg_wr_en_i) begin
      addr_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= '0;
      fields_q <= '0;
    end else if (advance) begin
      ctl_q    <= ctl_d;
      fields_q <= fields_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign checksum_ok_o  = res_q.checksum_ok;
  assign object_temp_o  = res_q.object_temp;
  assign ambient_temp_o = res_q.ambient_temp;
  assign body_temp_o    = res_q.body_temp;
  assign emissivity_o   = res_q.emissivity;

`ifndef NO_ASSERTIONS
  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(ctl_q.pos) < MAX_FRAME_BYTES))
    else $error("frame position past limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  a_restart_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (ctl_q.pos == '0 && ctl_q.sum == '0 && fields_q == '0))
    else $error("parser not restarted after frame");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.checksum_ok) |->
      (res_q.object_temp == '0 && res_q.ambient_temp == '0 &&
       res_q.body_temp == '0 && res_q.emissivity == '0))
    else $error("failed frame carries nonzero data");
`endif

endmodule
